[src/cogc_pkg.sv]
// Shared types and constants for the coarse occlusion grid cull block.
// Holds field widths, command and register codes, the sequencer state type
// and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package cogc_pkg;

    localparam int NDC_W      = 16;   // Q1.14 screen edge
    localparam int DEPTH_W    = 16;   // Q0.16 depth
    localparam int CELL_W     = 17;   // stored cell depth, all ones is infinity
    localparam int COORD_W    = 17;   // edge position in 1/1024 cell, up to 64 cells
    localparam int IDX_W      = 6;    // cell index, up to 64 cells per axis
    localparam int SCALE_W    = 7;    // grid size constant, up to 64
    localparam int PROD_W     = 22;   // edge offset times grid size
    localparam int BIAS_W     = 10;
    localparam int TOL_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CELL_W-1:0]        DEPTH_INF   = 17'h1FFFF;
    localparam logic signed [NDC_W-1:0]  NDC_ONE     = 16'sd16384;
    localparam logic signed [NDC_W-1:0]  NDC_NEG_ONE = -16'sd16384;

    // Commands
    localparam logic CMD_FRAME_START = 1'b0;
    localparam logic CMD_TEST        = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OCCLUSION_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_BIAS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TOLERANCE   = 2'd2;

    localparam logic [BIAS_W-1:0] DEPTH_BIAS_RESET     = 10'd66;
    localparam logic [TOL_W-1:0]  EDGE_TOLERANCE_RESET = 6'd1;

    typedef struct packed {
        logic              occlusion_enable;
        logic [BIAS_W-1:0] depth_bias;
        logic [TOL_W-1:0]  edge_tolerance;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] lc;
        logic [COORD_W-1:0] rc;
        logic [COORD_W-1:0] tc;
        logic [COORD_W-1:0] bc;
        logic [IDX_W-1:0]   min_x;
        logic [IDX_W-1:0]   max_x;
        logic [IDX_W-1:0]   min_y;
        logic [IDX_W-1:0]   max_y;
        logic               empty;
        logic [DEPTH_W-1:0] near_depth;
        logic [DEPTH_W-1:0] far_depth;
        logic               box_valid;
        logic               is_occluder;
    } box_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_START,
        ST_TEST,
        ST_WRITE,
        ST_EMIT
    } walk_state_t;

endpackage

[src/cogc_grid_ram.sv]
// Coarse depth grid storage: one write port and one registered read port.
// Depends on cogc_pkg for the cell width.
`timescale 1ns / 1ps

module cogc_grid_ram
    import cogc_pkg::*;
#(
    parameter int DEPTH  = 576,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CELL_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/cogc_setup.sv]
// Box setup: saturates the edges, maps them to grid coordinates in 1/1024
// cell and derives the clamped cell range. Depends on cogc_pkg.
`timescale 1ns / 1ps

module cogc_setup
    import cogc_pkg::*;
#(
    parameter int GRID_COLUMNS = 32,
    parameter int GRID_ROWS    = 18
)
(
    input  logic                     clk,
    input  logic                     load,
    input  logic signed [NDC_W-1:0]  screen_left,
    input  logic signed [NDC_W-1:0]  screen_right,
    input  logic signed [NDC_W-1:0]  screen_top,
    input  logic signed [NDC_W-1:0]  screen_bottom,
    input  logic [DEPTH_W-1:0]       near_depth,
    input  logic [DEPTH_W-1:0]       far_depth,
    input  logic                     box_valid,
    input  logic                     is_occluder,
    output box_t                     box
);

    localparam logic [SCALE_W-1:0] COLS_K = SCALE_W'(GRID_COLUMNS);
    localparam logic [SCALE_W-1:0] ROWS_K = SCALE_W'(GRID_ROWS);

    // Distance of a saturated edge from the left (or top) screen border.
    function automatic logic [NDC_W-1:0] edge_offset(
        input logic signed [NDC_W-1:0] v,
        input logic                    from_top
    );
        logic signed [NDC_W-1:0] c;
        logic [NDC_W:0]          d;
        c = v;
        if (v < NDC_NEG_ONE)
        begin
            c = NDC_NEG_ONE;
        end
        else if (v > NDC_ONE)
        begin
            c = NDC_ONE;
        end
        if (from_top)
        begin
            d = {1'b0, NDC_ONE} - {c[NDC_W-1], c};
        end
        else
        begin
            d = {c[NDC_W-1], c} + {1'b0, NDC_ONE};
        end
        return d[NDC_W-1:0];
    endfunction

    // offset * cells / 32, in 1/1024 cell
    function automatic logic [COORD_W-1:0] scale(
        input logic [NDC_W-1:0]   off,
        input logic [SCALE_W-1:0] cells
    );
        logic [PROD_W-1:0] p;
        p = PROD_W'(off) * PROD_W'(cells);
        return p[PROD_W-1:5];
    endfunction

    // floor(c / 1024) clamped to the grid
    function automatic logic [IDX_W-1:0] lower_idx(
        input logic [COORD_W-1:0] c,
        input logic [SCALE_W-1:0] cells
    );
        logic [SCALE_W-1:0] q;
        q = c[COORD_W-1:10];
        if (q > cells - 1'b1)
        begin
            q = cells - 1'b1;
        end
        return q[IDX_W-1:0];
    endfunction

    // ceil(c / 1024) - 1 clamped to the grid; a negative bound becomes zero
    function automatic logic [IDX_W-1:0] upper_idx(
        input logic [COORD_W-1:0] c,
        input logic [SCALE_W-1:0] cells
    );
        logic [COORD_W-1:0] s;
        logic [SCALE_W-1:0] q;
        s = c + COORD_W'(1023);
        q = s[COORD_W-1:10];
        if (q == '0)
        begin
            q = '0;
        end
        else
        begin
            q = q - 1'b1;
            if (q > cells - 1'b1)
            begin
                q = cells - 1'b1;
            end
        end
        return q[IDX_W-1:0];
    endfunction

    box_t box_reg;
    box_t box_next;

    always_comb
    begin
        box_next.lc          = scale(edge_offset(screen_left, 1'b0), COLS_K);
        box_next.rc          = scale(edge_offset(screen_right, 1'b0), COLS_K);
        box_next.tc          = scale(edge_offset(screen_bottom, 1'b1), ROWS_K);
        box_next.bc          = scale(edge_offset(screen_top, 1'b1), ROWS_K);
        box_next.min_x       = lower_idx(box_next.lc, COLS_K);
        box_next.max_x       = upper_idx(box_next.rc, COLS_K);
        box_next.min_y       = lower_idx(box_next.tc, ROWS_K);
        box_next.max_y       = upper_idx(box_next.bc, ROWS_K);
        box_next.empty       = (box_next.min_x > box_next.max_x) ||
                               (box_next.min_y > box_next.max_y);
        box_next.near_depth  = near_depth;
        box_next.far_depth   = far_depth;
        box_next.box_valid   = box_valid;
        box_next.is_occluder = is_occluder;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            box_reg <= box_next;
        end
    end

    assign box = box_reg;

endmodule

[src/cogc_walker.sv]
// Cell walker: clears the grid, runs the test pass and the occluder write
// pass over the box's cell range, and holds the result item.
// Depends on cogc_pkg; drives the ports of cogc_grid_ram.
`timescale 1ns / 1ps

module cogc_walker
    import cogc_pkg::*;
#(
    parameter int GRID_COLUMNS = 32,
    parameter int CELL_COUNT   = 576,
    parameter int ADDR_W       = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  box_t              box,
    input  cfg_t              cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              occluded,
    output logic              mem_wr_en,
    output logic [ADDR_W-1:0] mem_wr_addr,
    output logic [CELL_W-1:0] mem_wr_data,
    output logic              mem_rd_en,
    output logic [ADDR_W-1:0] mem_rd_addr,
    input  logic [CELL_W-1:0] mem_rd_data
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(GRID_COLUMNS);

    walk_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              issue_done_reg, issue_done_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  x_reg, x_next;
    logic [IDX_W-1:0]  y_reg, y_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              pend_cov_reg, pend_cov_next;
    logic              cover_reg, cover_next;
    logic              result_reg, result_next;
    logic              occluded_reg, occluded_next;

    logic [ADDR_W-1:0]  cur_addr;
    logic               x_last;
    logic               last_cell;
    logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic               cell_cov;
    logic               depth_ok;
    logic               write_hit;
    logic               out_load;

    assign cur_addr  = ADDR_W'(y_reg) * ROW_STEP + ADDR_W'(x_reg);
    assign x_last    = (x_reg == box.max_x);
    assign last_cell = x_last && (y_reg == box.max_y);

    // Full coverage of the current cell, with the edge slack
    assign x_lo = COORD_W'({x_reg, 10'b0}) + COORD_W'(cfg.edge_tolerance);
    assign x_hi = ((COORD_W'(x_reg) + COORD_W'(1)) << 10) - COORD_W'(cfg.edge_tolerance);
    assign y_lo = COORD_W'({y_reg, 10'b0}) + COORD_W'(cfg.edge_tolerance);
    assign y_hi = ((COORD_W'(y_reg) + COORD_W'(1)) << 10) - COORD_W'(cfg.edge_tolerance);
    assign cell_cov = (x_lo >= box.lc) && (x_hi <= box.rc) &&
                      (y_lo >= box.tc) && (y_hi <= box.bc);

    // cell < near - bias, kept unsigned
    assign depth_ok  = ((CELL_W + 1)'(mem_rd_data) + (CELL_W + 1)'(cfg.depth_bias))
                       < (CELL_W + 1)'(box.near_depth);
    assign write_hit = pend_cov_reg && (CELL_W'(box.far_depth) < mem_rd_data);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        pend_last_next  = pend_last_reg;
        pend_addr_next  = pend_addr_reg;
        pend_cov_next   = pend_cov_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        cover_next      = cover_reg;
        result_next     = result_reg;
        out_load        = 1'b0;
        in_ready        = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pend_addr_reg;
        mem_wr_data     = CELL_W'(box.far_depth);
        mem_rd_en       = 1'b0;
        mem_rd_addr     = cur_addr;

        // Shared cell issue for both passes: read one cell per cycle
        if ((state_reg == ST_TEST || state_reg == ST_WRITE) && !issue_done_reg)
        begin
            mem_rd_en      = 1'b1;
            pend_next      = 1'b1;
            pend_last_next = last_cell;
            pend_addr_next = cur_addr;
            pend_cov_next  = cell_cov;
            if (last_cell)
            begin
                issue_done_next = 1'b1;
            end
            else if (x_last)
            begin
                x_next = box.min_x;
                y_next = y_reg + 1'b1;
            end
            else
            begin
                x_next = x_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command == CMD_FRAME_START)
                    begin
                        clr_addr_next = '0;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end

            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = DEPTH_INF;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            ST_START:
            begin
                x_next          = box.min_x;
                y_next          = box.min_y;
                issue_done_next = 1'b0;
                cover_next      = 1'b1;
                result_next     = 1'b0;
                if (!box.box_valid || !cfg.occlusion_enable || box.empty)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_TEST;
                end
            end

            ST_TEST:
            begin
                if (pend_reg)
                begin
                    cover_next = cover_reg && depth_ok;
                    if (pend_last_reg)
                    begin
                        if (cover_reg && depth_ok)
                        begin
                            result_next = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        else if (box.is_occluder)
                        begin
                            x_next          = box.min_x;
                            y_next          = box.min_y;
                            issue_done_next = 1'b0;
                            state_next      = ST_WRITE;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_WRITE:
            begin
                if (pend_reg)
                begin
                    mem_wr_en = write_hit;
                    if (pend_last_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);
    assign occluded_next  = out_load ? result_reg : occluded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            issue_done_reg <= 1'b1;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        pend_addr_reg <= pend_addr_next;
        pend_cov_reg  <= pend_cov_next;
        cover_reg     <= cover_next;
        result_reg    <= result_next;
        occluded_reg  <= occluded_next;
    end

    assign out_valid = out_valid_reg;
    assign occluded  = occluded_reg;

endmodule

[src/coarse_occlusion_grid_cull.sv]
// Top level of the coarse occlusion grid cull block: configuration
// registers and the setup, walker and grid memory instances.
// Depends on cogc_pkg, cogc_setup, cogc_walker and cogc_grid_ram.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// -------   ------------------------  ----------------------------------------
// input     in_valid / in_ready       command, screen_left/right/top/bottom,
//                                     near_depth, far_depth, box_valid,
//                                     is_occluder
// output    out_valid / out_ready     occluded
// config    cfg_write_en (no wait)    cfg_index, cfg_data
//
// Passes: a test item walks every cell in its range once for the test pass
//   and, when it is a visible occluder, once more for the write pass; invalid,
//   disabled or empty boxes skip both passes. Both passes go through the
//   single grid read port, one cell per cycle. A frame-start item clears
//   every cell (one cell cleared per cycle) and gives no result.
// Reset: the same clearing pass runs after reset; in_ready stays low until
//   it ends. Config writes are taken always.
// Stalls: the result sits in an output register; the walker waits only when
//   that register is still full and the next result is ready.

module coarse_occlusion_grid_cull
    import cogc_pkg::*;
#(
    parameter int GRID_COLUMNS = 32,
    parameter int GRID_ROWS    = 18
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic signed [NDC_W-1:0]  screen_left,
    input  logic signed [NDC_W-1:0]  screen_right,
    input  logic signed [NDC_W-1:0]  screen_top,
    input  logic signed [NDC_W-1:0]  screen_bottom,
    input  logic [DEPTH_W-1:0]       near_depth,
    input  logic [DEPTH_W-1:0]       far_depth,
    input  logic                     box_valid,
    input  logic                     is_occluder,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     occluded,
    input  logic                     cfg_write_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    cfg_t              cfg_reg;
    box_t              box;
    logic              item_load;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [CELL_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [CELL_W-1:0] mem_rd_data;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.occlusion_enable <= 1'b1;
            cfg_reg.depth_bias       <= DEPTH_BIAS_RESET;
            cfg_reg.edge_tolerance   <= EDGE_TOLERANCE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_OCCLUSION_ENABLE: cfg_reg.occlusion_enable <= cfg_data[0];
                CFG_DEPTH_BIAS:       cfg_reg.depth_bias       <= cfg_data[BIAS_W-1:0];
                CFG_EDGE_TOLERANCE:   cfg_reg.edge_tolerance   <= cfg_data[TOL_W-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Capture the box geometry with every accepted item.
    assign item_load = in_valid && in_ready;

    cogc_setup #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_setup (
        .clk           (clk),
        .load          (item_load),
        .screen_left   (screen_left),
        .screen_right  (screen_right),
        .screen_top    (screen_top),
        .screen_bottom (screen_bottom),
        .near_depth    (near_depth),
        .far_depth     (far_depth),
        .box_valid     (box_valid),
        .is_occluder   (is_occluder),
        .box           (box)
    );

    // Walk the cell range: the test pass reads, the write pass reads, takes
    // the minimum on fully covered cells and writes back in the next cycle.
    // Passes never overlap and each visits a cell once; no forwarding needed.
    cogc_walker #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .CELL_COUNT   (CELL_COUNT),
        .ADDR_W       (ADDR_W)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .box         (box),
        .cfg         (cfg_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .occluded    (occluded),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    cogc_grid_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

[src/cogc_checker.sv]
// Port-level checks for coarse_occlusion_grid_cull and the bind that
// attaches them. Depends on the top level's ports only.
`timescale 1ns / 1ps

module cogc_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic occluded
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(occluded))
        else $error("result changed or dropped while stalled");

    // Every accepted item keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

    // A new result only shows up while an item is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind coarse_occlusion_grid_cull cogc_checker u_cogc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .occluded  (occluded)
);
